// ----- hw/rtl/mpw_pkg.sv -----
`default_nettype none

package mpw_pkg;

  // default sizing
  localparam int MAX_WIDTH_DEF    = 64;
  localparam int MAX_HEIGHT_DEF   = 64;
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MAX_WINDOW_DEF   = 4;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int MAX_STEP    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 7;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_CHANNELS  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_ROWS     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COLS     = 3'd6;

  // fixed-width job fields beyond the sized ones: produce, wrow, wcol, channel, last
  localparam int JOB_FIXED_BITS = 1 + 6 + 6 + 4 + 1;

  // configuration after range limiting
  typedef struct packed {
    logic [4:0] num_channels;
    logic [6:0] frame_height;
    logic [6:0] frame_width;
    logic [2:0] window_height;
    logic [2:0] window_width;
    logic [2:0] step_rows;
    logic [2:0] step_cols;
  } cfg_t;

  typedef struct packed {
    logic [15:0] q;
    logic [2:0]  r;
  } divmod_t;

  function automatic int idx_bits(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int job_width(int sb, int mw, int mc, int mwin);
    return sb + idx_bits(mwin) + idx_bits(mw) + idx_bits(mc) + JOB_FIXED_BITS;
  endfunction

  // quotient and remainder by a stride of 1..4; thirds via reciprocal multiply
  function automatic divmod_t divmod_step(logic [15:0] d, logic [2:0] s);
    logic [32:0] prod;
    divmod_t     res;
    prod = '0;
    res  = '0;
    case (s)
      3'd2: begin
        res.q = d >> 1;
        res.r = {2'b00, d[0]};
      end
      3'd3: begin
        prod  = {17'd0, d} * 33'd43691;
        res.q = prod[32:17];
        res.r = 3'(d - 16'(res.q * 16'd3));
      end
      3'd4: begin
        res.q = d >> 2;
        res.r = {1'b0, d[1:0]};
      end
      default: begin
        res.q = d;
        res.r = 3'd0;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mpw_ram.sv -----
`default_nettype none

module mpw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = mpw_pkg::idx_bits(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpw_queue.sv -----
`default_nettype none

module mpw_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = mpw_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  localparam int PW = mpw_pkg::idx_bits(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNTW-1:0]  count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNTW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpw_front.sv -----
`default_nettype none

module mpw_front #(
  parameter int MAX_WIDTH    = mpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = mpw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS = mpw_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_WINDOW   = mpw_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS  = mpw_pkg::SAMPLE_BITS_DEF,
  localparam int JOB_W = mpw_pkg::job_width(SAMPLE_BITS, MAX_WIDTH, MAX_CHANNELS, MAX_WINDOW)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mpw_pkg::cfg_t          cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   frame_start,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output logic      [JOB_W-1:0]       job_data
);

  localparam int GW = mpw_pkg::idx_bits(MAX_WINDOW);
  localparam int CW = mpw_pkg::idx_bits(MAX_WIDTH);
  localparam int RW = mpw_pkg::idx_bits(MAX_HEIGHT);
  localparam int HW = mpw_pkg::idx_bits(MAX_CHANNELS);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [GW-1:0]          ring;
    logic [CW-1:0]          col;
    logic [HW-1:0]          ch;
    logic                   produce;
    logic [5:0]             wrow;
    logic [5:0]             wcol;
    logic [3:0]             out_ch;
    logic                   last;
  } job_t;

  logic [RW-1:0] row_count;
  logic [CW-1:0] column_count;
  logic [HW-1:0] channel_count;
  logic [GW-1:0] ring_row;       // row_count modulo MAX_WINDOW

  logic [RW-1:0] row_cur, row_next;
  logic [CW-1:0] col_cur, col_next;
  logic [HW-1:0] ch_cur, ch_next;
  logic [GW-1:0] ring_cur, ring_next;
  logic [15:0]   r16, c16, ch16;
  logic          row_ok, col_ok, ch_last;
  mpw_pkg::divmod_t dv_row, dv_col, lim_row, lim_col;
  job_t          job;
  logic          fire;

  always_comb begin
    row_cur  = frame_start ? '0 : row_count;
    col_cur  = frame_start ? '0 : column_count;
    ch_cur   = frame_start ? '0 : channel_count;
    ring_cur = frame_start ? '0 : ring_row;
    r16  = 16'(row_cur);
    c16  = 16'(col_cur);
    ch16 = 16'(ch_cur);

    row_ok = (r16 < 16'(cfg.frame_height)) && (r16 + 16'd1 >= 16'(cfg.window_height));
    col_ok = (c16 < 16'(cfg.frame_width)) && (c16 + 16'd1 >= 16'(cfg.window_width));
    ch_last = (ch16 + 16'd1 >= 16'(cfg.num_channels));

    dv_row  = mpw_pkg::divmod_step(r16 + 16'd1 - 16'(cfg.window_height), cfg.step_rows);
    dv_col  = mpw_pkg::divmod_step(c16 + 16'd1 - 16'(cfg.window_width), cfg.step_cols);
    lim_row = mpw_pkg::divmod_step(16'(cfg.frame_height) - 16'(cfg.window_height),
                                   cfg.step_rows);
    lim_col = mpw_pkg::divmod_step(16'(cfg.frame_width) - 16'(cfg.window_width),
                                   cfg.step_cols);

    job.sample  = sample;
    job.ring    = ring_cur;
    job.col     = col_cur;
    job.ch      = ch_cur;
    job.produce = row_ok && col_ok && (dv_row.r == 3'd0) && (dv_col.r == 3'd0);
    job.wrow    = 6'(dv_row.q);
    job.wcol    = 6'(dv_col.q);
    job.out_ch  = 4'(ch_cur);
    job.last    = (dv_row.q == lim_row.q) && (dv_col.q == lim_col.q) && ch_last;

    // raster advance, channel innermost; a counter past its bound wraps
    row_next  = row_cur;
    col_next  = col_cur;
    ch_next   = ch_cur;
    ring_next = ring_cur;
    if (ch_last) begin
      ch_next = '0;
      if (c16 + 16'd1 >= 16'(cfg.frame_width)) begin
        col_next = '0;
        if (r16 + 16'd1 >= 16'(cfg.frame_height)) begin
          row_next  = '0;
          ring_next = '0;
        end else begin
          row_next  = row_cur + 1'b1;
          ring_next = (ring_cur == GW'(MAX_WINDOW - 1)) ? '0 : ring_cur + 1'b1;
        end
      end else begin
        col_next = col_cur + 1'b1;
      end
    end else begin
      ch_next = ch_cur + 1'b1;
    end
  end

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign job_data  = job;
  assign fire      = in_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      column_count  <= '0;
      channel_count <= '0;
      ring_row      <= '0;
    end else if (fire) begin
      row_count     <= row_next;
      column_count  <= col_next;
      channel_count <= ch_next;
      ring_row      <= ring_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpw_back.sv -----
`default_nettype none

module mpw_back #(
  parameter int MAX_WIDTH    = mpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = mpw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS = mpw_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_WINDOW   = mpw_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS  = mpw_pkg::SAMPLE_BITS_DEF,
  localparam int JOB_W = mpw_pkg::job_width(SAMPLE_BITS, MAX_WIDTH, MAX_CHANNELS, MAX_WINDOW)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mpw_pkg::cfg_t          cfg,
  input  wire logic                   job_valid,
  output logic                        job_ready,
  input  wire logic [JOB_W-1:0]       job_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [SAMPLE_BITS-1:0] max_value,
  output logic      [3:0]             out_channel,
  output logic      [5:0]             window_row,
  output logic      [5:0]             window_col,
  output logic                        frame_last
);

  localparam int GW = mpw_pkg::idx_bits(MAX_WINDOW);
  localparam int CW = mpw_pkg::idx_bits(MAX_WIDTH);
  localparam int HW = mpw_pkg::idx_bits(MAX_CHANNELS);
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH * MAX_CHANNELS;
  localparam int AW = mpw_pkg::idx_bits(DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH * MAX_CHANNELS);
  localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_CHANNELS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [GW-1:0]          ring;
    logic [CW-1:0]          col;
    logic [HW-1:0]          ch;
    logic                   produce;
    logic [5:0]             wrow;
    logic [5:0]             wcol;
    logic [3:0]             out_ch;
    logic                   last;
  } job_t;

  logic [1:0]             state;
  job_t                   j_in;
  job_t                   job;
  logic [GW-1:0]          yi;
  logic [GW-1:0]          xi;
  logic [SAMPLE_BITS-1:0] best;
  logic [SAMPLE_BITS-1:0] best_next;
  logic                   rd_pend;
  logic                   read_done;
  logic                   row_wrap;
  logic                   load_out;
  logic [GW:0]            slot_w;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign j_in      = job_data;
  assign job_ready = (state == S_IDLE);
  assign ram_we    = (state == S_IDLE) && job_valid;
  assign row_wrap  = (4'(xi) + 4'd1 == 4'(cfg.window_width));
  assign read_done = row_wrap && (4'(yi) + 4'd1 == 4'(cfg.window_height));
  assign load_out  = (state == S_HOLD) && (!out_valid || out_ready);

  always_comb begin
    // ring slot of row (current - yi); never negative in real rows
    slot_w = {1'b0, job.ring} + ((job.ring >= yi) ? '0 : (GW + 1)'(MAX_WINDOW))
             - (GW + 1)'(yi);
    if (ram_we) begin
      ram_addr = AW'(j_in.ring) * ROW_STRIDE + AW'(j_in.col) * COL_STRIDE + AW'(j_in.ch);
    end else begin
      ram_addr = AW'(slot_w[GW-1:0]) * ROW_STRIDE
                 + AW'(job.col - CW'(xi)) * COL_STRIDE + AW'(job.ch);
    end
    best_next = (rd_pend && ($signed(ram_rdata) > $signed(best))) ? ram_rdata : best;
  end

  mpw_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (j_in.sample),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid && j_in.produce) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (read_done) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          job  <= j_in;
          best <= j_in.sample;
          yi   <= '0;
          xi   <= '0;
        end
      end
      S_READ: begin
        best <= best_next;
        if (row_wrap) begin
          xi <= '0;
          yi <= yi + 1'b1;
        end else begin
          xi <= xi + 1'b1;
        end
      end
      S_DRAIN: begin
        best <= best_next;
      end
      S_HOLD: begin
        if (load_out) begin
          max_value   <= best;
          out_channel <= job.out_ch;
          window_row  <= job.wrow;
          window_col  <= job.wcol;
          frame_last  <= job.last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/max_pooling_window_stream.sv -----
// Channel     Dir  Signals                        Contents
// s_axis      in   tvalid tready tdata tuser      sample; frame_start
// m_axis      out  tvalid tready tdata tlast      max/channel/row/col; frame_last
// cfg         in   cfg_we cfg_index cfg_data      register writes, no read-back
//
// A sample that closes no window only writes the line store. A sample that
// closes a window writes the store, then reads the line store once per window
// entry through the single RAM port, folds the last read in a drain state and
// loads the output register in a hold state, which waits while an untaken
// result is still held there. A two-entry queue lets the front keep taking
// samples while the back works and while a result waits in the output
// register. Reset is synchronous; the line store is not cleared and needs no sweep.
`default_nettype none

module max_pooling_window_stream #(
  parameter int MAX_WIDTH    = mpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = mpw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS = mpw_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_WINDOW   = mpw_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS  = mpw_pkg::SAMPLE_BITS_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = SAMPLE_BITS + 16,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]                 s_axis_tdata,  // sample
  input  wire logic                                  s_axis_tuser,  // frame_start
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // max_value, out_channel[3:0], window_row[5:0], window_col[5:0]
  output logic      [OUT_TDATA_W-1:0]                m_axis_tdata,
  output logic                                       m_axis_tlast,  // frame_last
  input  wire logic                                  cfg_we,
  input  wire logic [mpw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [mpw_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int JOB_W = mpw_pkg::job_width(SAMPLE_BITS, MAX_WIDTH, MAX_CHANNELS, MAX_WINDOW);

  logic [4:0] num_channels;
  logic [6:0] frame_height;
  logic [6:0] frame_width;
  logic [2:0] window_height;
  logic [2:0] window_width;
  logic [2:0] step_rows;
  logic [2:0] step_cols;

  mpw_pkg::cfg_t          cfg;
  logic                   fq_valid, fq_ready;
  logic [JOB_W-1:0]       fq_data;
  logic                   qb_valid, qb_ready;
  logic [JOB_W-1:0]       qb_data;
  logic [SAMPLE_BITS-1:0] max_value;
  logic [3:0]             out_channel;
  logic [5:0]             window_row;
  logic [5:0]             window_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels  <= 5'd1;
      frame_height  <= 7'd64;
      frame_width   <= 7'd64;
      window_height <= 3'd2;
      window_width  <= 3'd2;
      step_rows     <= 3'd2;
      step_cols     <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        mpw_pkg::REG_NUM_CHANNELS:  num_channels  <= cfg_data[4:0];
        mpw_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        mpw_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        mpw_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data[2:0];
        mpw_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data[2:0];
        mpw_pkg::REG_STEP_ROWS:     step_rows     <= cfg_data[2:0];
        mpw_pkg::REG_STEP_COLS:     step_cols     <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // limit every register to its legal range
  always_comb begin
    cfg.num_channels  = (num_channels == '0) ? 5'd1 :
                        (int'(num_channels) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : num_channels;
    cfg.frame_height  = (frame_height == '0) ? 7'd1 :
                        (int'(frame_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : frame_height;
    cfg.frame_width   = (frame_width == '0) ? 7'd1 :
                        (int'(frame_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : frame_width;
    cfg.window_height = (window_height == '0) ? 3'd1 :
                        (int'(window_height) > MAX_WINDOW) ? 3'(MAX_WINDOW) : window_height;
    cfg.window_width  = (window_width == '0) ? 3'd1 :
                        (int'(window_width) > MAX_WINDOW) ? 3'(MAX_WINDOW) : window_width;
    cfg.step_rows     = (step_rows == '0) ? 3'd1 :
                        (int'(step_rows) > mpw_pkg::MAX_STEP) ? 3'(mpw_pkg::MAX_STEP) : step_rows;
    cfg.step_cols     = (step_cols == '0) ? 3'd1 :
                        (int'(step_cols) > mpw_pkg::MAX_STEP) ? 3'(mpw_pkg::MAX_STEP) : step_cols;
  end

  mpw_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .frame_start (s_axis_tuser),
    .job_valid   (fq_valid),
    .job_ready   (fq_ready),
    .job_data    (fq_data)
  );

  mpw_queue #(
    .WIDTH (JOB_W),
    .DEPTH (mpw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  mpw_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job_valid   (qb_valid),
    .job_ready   (qb_ready),
    .job_data    (qb_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .max_value   (max_value),
    .out_channel (out_channel),
    .window_row  (window_row),
    .window_col  (window_col),
    .frame_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({window_col, window_row, out_channel, max_value});

endmodule

`default_nettype wire

// ----- hw/rtl/mpw_checker.sv -----
`default_nettype none

module mpw_checker #(
  parameter int SAMPLE_BITS  = mpw_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = mpw_pkg::MAX_CHANNELS_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 16 + 7) / 8) * 8
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]              s_axis_tdata,
  input wire logic                               s_axis_tuser,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0]             m_axis_tdata,
  input wire logic                               m_axis_tlast,
  input wire logic                               cfg_we,
  input wire logic [mpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input wire logic [mpw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [31:0] in_total;
  logic [31:0] out_total;
  logic [4:0]  nc_raw;
  logic [8:0]  nc_lim;
  logic [3:0]  last_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_total  <= '0;
      out_total <= '0;
      nc_raw    <= 5'd1;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_total <= in_total + 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_total <= out_total + 1'b1;
      end
      if (cfg_we && (cfg_index == mpw_pkg::REG_NUM_CHANNELS)) begin
        nc_raw <= cfg_data[4:0];
      end
    end
  end

  assign nc_lim  = (nc_raw == '0) ? 9'd1 :
                   (int'(nc_raw) > MAX_CHANNELS) ? 9'(MAX_CHANNELS) : 9'(nc_raw);
  assign last_ch = 4'(nc_lim - 9'd1);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present right after reset");

  // never more results than samples taken
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> in_total > out_total)
    else $error("result without a matching sample");

  // the frame's last result closes the last channel (or a counter left past it)
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[SAMPLE_BITS +: 4] >= last_ch)
    else $error("frame end flagged before the last channel");

endmodule

bind max_pooling_window_stream mpw_checker #(
  .SAMPLE_BITS  (SAMPLE_BITS),
  .MAX_CHANNELS (MAX_CHANNELS)
) u_mpw_chk (.*);

`default_nettype wire

// ----- tb/max_pooling_window_stream_tb.sv -----
`default_nettype none

module max_pooling_window_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT     = 2000;
  localparam int TAIL_CYCLES    = 48;
  localparam int TARGET_SAMPLES = 1350;
  localparam int CALM_AFTER     = 1150;
  localparam int DRAIN_AT       = 700;
  localparam int STORE_DEPTH    = mpw_pkg::MAX_WINDOW_DEF * mpw_pkg::MAX_WIDTH_DEF
                                  * mpw_pkg::MAX_CHANNELS_DEF;
  localparam logic [mpw_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;  // decodes to no register

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  chan;
    logic [5:0]  wrow;
    logic [5:0]  wcol;
    logic        last;
  } pool_res_t;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [mpw_pkg::CFG_INDEX_BITS-1:0] reg_idx;
    logic [mpw_pkg::CFG_DATA_BITS-1:0]  reg_val;
    logic [15:0]                        value;
    logic                               fs;
    logic                               typed;
    pool_res_t                          res;
  } stim_row_t;

  logic                               clk;
  logic                               rst;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [15:0]                        s_axis_tdata;   // sample
  logic                               s_axis_tuser;   // frame_start
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [31:0]                        m_axis_tdata;   // max_value, out_channel, window_row, window_col
  logic                               m_axis_tlast;   // frame_last
  logic                               cfg_we;
  logic [mpw_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [mpw_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  max_pooling_window_stream u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // pooling state mirror
  int          eff_nc, eff_fh, eff_fw, eff_wh, eff_ww, eff_sr, eff_sc;
  int          row_pos, col_pos, chan_pos;
  logic [15:0] line_mem  [STORE_DEPTH];
  bit          line_seen [STORE_DEPTH];

  pool_res_t   due_maxima[$];
  stim_row_t   dir_rows[$];
  int          mismatches;
  int          samples_sent;
  int          stalled_cycles;
  bit          idle_on;
  bit          calm_tail;
  bit          drained;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int mem_addr(int r, int c, int ch);
    return ((r % mpw_pkg::MAX_WINDOW_DEF) * mpw_pkg::MAX_WIDTH_DEF
            + (c % mpw_pkg::MAX_WIDTH_DEF)) * mpw_pkg::MAX_CHANNELS_DEF
           + (ch % mpw_pkg::MAX_CHANNELS_DEF);
  endfunction

  function automatic void apply_reg(logic [mpw_pkg::CFG_INDEX_BITS-1:0] idx,
                                    logic [mpw_pkg::CFG_DATA_BITS-1:0] val);
    case (idx)
      mpw_pkg::REG_NUM_CHANNELS:
        eff_nc = clampi(int'(val[4:0]), 1, mpw_pkg::MAX_CHANNELS_DEF);
      mpw_pkg::REG_FRAME_HEIGHT:
        eff_fh = clampi(int'(val), 1, mpw_pkg::MAX_HEIGHT_DEF);
      mpw_pkg::REG_FRAME_WIDTH:
        eff_fw = clampi(int'(val), 1, mpw_pkg::MAX_WIDTH_DEF);
      mpw_pkg::REG_WINDOW_HEIGHT:
        eff_wh = clampi(int'(val[2:0]), 1, mpw_pkg::MAX_WINDOW_DEF);
      mpw_pkg::REG_WINDOW_WIDTH:
        eff_ww = clampi(int'(val[2:0]), 1, mpw_pkg::MAX_WINDOW_DEF);
      mpw_pkg::REG_STEP_ROWS:
        eff_sr = clampi(int'(val[2:0]), 1, mpw_pkg::MAX_STEP);
      mpw_pkg::REG_STEP_COLS:
        eff_sc = clampi(int'(val[2:0]), 1, mpw_pkg::MAX_STEP);
      default: ;
    endcase
  endfunction

  // true when (r, c) is the bottom-right corner of an in-frame window on the stride grid
  function automatic bit closes_window(int r, int c);
    return r < eff_fh && c < eff_fw && r + 1 >= eff_wh && c + 1 >= eff_ww &&
           (r + 1 - eff_wh) % eff_sr == 0 && (c + 1 - eff_ww) % eff_sc == 0;
  endfunction

  function automatic bit reads_unseen();
    if (!closes_window(row_pos, col_pos)) return 1'b0;
    for (int y = 0; y < eff_wh; y++)
      for (int x = 0; x < eff_ww; x++)
        if ((y != 0 || x != 0) && !line_seen[mem_addr(row_pos - y, col_pos - x, chan_pos)])
          return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit pool_sample(logic [15:0] value, logic fs, output pool_res_t res);
    int best;
    int v;
    int wr;
    int wc;
    bit hit;
    if (fs) begin
      row_pos  = 0;
      col_pos  = 0;
      chan_pos = 0;
    end
    line_mem[mem_addr(row_pos, col_pos, chan_pos)]  = value;
    line_seen[mem_addr(row_pos, col_pos, chan_pos)] = 1'b1;
    hit = closes_window(row_pos, col_pos);
    res = '0;
    if (hit) begin
      best = $signed(value);
      for (int y = 0; y < eff_wh; y++)
        for (int x = 0; x < eff_ww; x++) begin
          v = $signed(line_mem[mem_addr(row_pos - y, col_pos - x, chan_pos)]);
          if (v > best) best = v;
        end
      wr = (row_pos + 1 - eff_wh) / eff_sr;
      wc = (col_pos + 1 - eff_ww) / eff_sc;
      res.value = best[15:0];
      res.chan  = chan_pos[3:0];
      res.wrow  = wr[5:0];
      res.wcol  = wc[5:0];
      res.last  = wr == (eff_fh - eff_wh) / eff_sr && wc == (eff_fw - eff_ww) / eff_sc &&
                  chan_pos + 1 >= eff_nc;
    end
    if (chan_pos + 1 >= eff_nc) begin
      chan_pos = 0;
      if (col_pos + 1 >= eff_fw) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= eff_fh) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    end else begin
      chan_pos++;
    end
    return hit;
  endfunction

  function automatic void add_reg(logic [mpw_pkg::CFG_INDEX_BITS-1:0] idx,
                                  logic [mpw_pkg::CFG_DATA_BITS-1:0] val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_sample(logic [15:0] value, logic fs);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_SAMPLE;
    row.value = value;
    row.fs    = fs;
    dir_rows.push_back(row);
  endfunction

  // 1x1 window rows: the maximum is the sample itself
  function automatic void add_checked(logic [15:0] value, logic fs, logic [3:0] chan,
                                      logic [5:0] wrow, logic [5:0] wcol, logic last);
    stim_row_t row;
    row           = '0;
    row.kind      = ROW_SAMPLE;
    row.value     = value;
    row.fs        = fs;
    row.typed     = 1'b1;
    row.res.value = value;
    row.res.chan  = chan;
    row.res.wrow  = wrow;
    row.res.wcol  = wcol;
    row.res.last  = last;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, pool_res_t want, pool_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %0d ch%0d r%0d c%0d l%0b, got %0d ch%0d r%0d c%0d l%0b",
               what, $signed(want.value), want.chan, want.wrow, want.wcol, want.last,
               $signed(got.value), got.chan, got.wrow, got.wcol, got.last);
  endtask

  // leaves cfg_we high so back-to-back writes need no toggle; caller lowers it
  task automatic write_reg(logic [mpw_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [mpw_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_maxima.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(logic [15:0] value, logic fs, logic typed, pool_res_t typed_res);
    pool_res_t res;
    bit        hit;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    // never let a window cover a store entry that was never written
    if (!fs && reads_unseen()) fs = 1'b1;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= fs;
    do @(posedge clk); while (!s_axis_tready);
    hit = pool_sample(value, fs, res);
    if (typed) due_maxima.push_back(typed_res);
    else if (hit) due_maxima.push_back(res);
    samples_sent++;
  endtask

  task automatic run_phase(logic [6:0] nc, logic [6:0] fh, logic [6:0] fw, logic [6:0] wh,
                           logic [6:0] ww, logic [6:0] sr, logic [6:0] sc, int count, bit fresh);
    logic [15:0] value;
    logic        fs;
    settle();
    write_reg(mpw_pkg::REG_NUM_CHANNELS, nc);
    write_reg(mpw_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(mpw_pkg::REG_FRAME_WIDTH, fw);
    write_reg(mpw_pkg::REG_WINDOW_HEIGHT, wh);
    write_reg(mpw_pkg::REG_WINDOW_WIDTH, ww);
    write_reg(mpw_pkg::REG_STEP_ROWS, sr);
    write_reg(mpw_pkg::REG_STEP_COLS, sc);
    cfg_we    <= 1'b0;
    calm_tail = samples_sent >= CALM_AFTER;
    idle_on   = !calm_tail && $urandom_range(0, 3) != 0;
    for (int i = 0; i < count; i++) begin
      if (!drained && samples_sent >= DRAIN_AT) begin
        drained = 1'b1;
        settle();
      end
      case ($urandom_range(0, 9))
        0:       value = 16'h8000;
        1:       value = 16'h7FFF;
        default: value = 16'($urandom);
      endcase
      fs = (i == 0) ? fresh : ($urandom_range(0, 49) == 0);
      send_sample(value, fs, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    pool_res_t got;
    pool_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[15:0];
      got.chan  = m_axis_tdata[19:16];
      got.wrow  = m_axis_tdata[25:20];
      got.wcol  = m_axis_tdata[31:26];
      got.last  = m_axis_tlast;
      if (due_maxima.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = due_maxima.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // receiver back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    bit         in_regs;
    logic [6:0] r_nc, r_fh, r_fw, r_wh, r_ww, r_sr, r_sc;
    int         frame;
    int         count;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    samples_sent   = 0;
    idle_on        = 1'b1;
    calm_tail      = 1'b0;
    drained        = 1'b0;
    eff_nc = 1;  eff_fh = 64; eff_fw = 64;
    eff_wh = 2;  eff_ww = 2;  eff_sr = 2;  eff_sc = 2;
    row_pos = 0; col_pos = 0; chan_pos = 0;

    // reset defaults: nothing closes in row 0
    add_sample(16'h4000, 1'b0);
    add_sample(16'hC000, 1'b0);
    // 2x2 frame, two channels, 1x1 window: every sample comes straight back
    add_reg(mpw_pkg::REG_NUM_CHANNELS, 7'd2);
    add_reg(mpw_pkg::REG_FRAME_HEIGHT, 7'd2);
    add_reg(mpw_pkg::REG_FRAME_WIDTH, 7'd2);
    add_reg(mpw_pkg::REG_WINDOW_HEIGHT, 7'd1);
    add_reg(mpw_pkg::REG_WINDOW_WIDTH, 7'd1);
    add_reg(mpw_pkg::REG_STEP_ROWS, 7'd1);
    add_reg(mpw_pkg::REG_STEP_COLS, 7'd1);
    add_checked(16'h8000, 1'b1, 4'd0, 6'd0, 6'd0, 1'b0);
    add_checked(16'h7FFF, 1'b0, 4'd1, 6'd0, 6'd0, 1'b0);
    add_checked(16'h0000, 1'b0, 4'd0, 6'd0, 6'd1, 1'b0);
    add_checked(16'hFFFF, 1'b0, 4'd1, 6'd0, 6'd1, 1'b0);
    add_checked(16'h0001, 1'b0, 4'd0, 6'd1, 6'd0, 1'b0);
    add_checked(16'h5555, 1'b0, 4'd1, 6'd1, 6'd0, 1'b0);
    add_checked(16'hAAAA, 1'b0, 4'd0, 6'd1, 6'd1, 1'b0);
    add_checked(16'h007B, 1'b0, 4'd1, 6'd1, 6'd1, 1'b1);
    // frame end wraps without frame_start
    add_checked(16'h0007, 1'b0, 4'd0, 6'd0, 6'd0, 1'b0);
    // frame_start mid-frame
    add_checked(16'hFED4, 1'b1, 4'd0, 6'd0, 6'd0, 1'b0);
    add_checked(16'h0063, 1'b0, 4'd1, 6'd0, 6'd0, 1'b0);
    // window taller than the frame: silent
    add_reg(mpw_pkg::REG_WINDOW_HEIGHT, 7'd3);
    add_sample(16'h1111, 1'b0);
    add_sample(16'hEEEE, 1'b0);
    add_sample(16'h8001, 1'b0);
    // out-of-range values saturate; index 7 is ignored
    add_reg(REG_SPARE, 7'h7F);
    add_reg(mpw_pkg::REG_NUM_CHANNELS, 7'd31);
    add_reg(mpw_pkg::REG_FRAME_HEIGHT, 7'd0);
    add_reg(mpw_pkg::REG_FRAME_WIDTH, 7'h7F);
    add_reg(mpw_pkg::REG_WINDOW_HEIGHT, 7'd0);
    add_reg(mpw_pkg::REG_WINDOW_WIDTH, 7'd0);
    add_reg(mpw_pkg::REG_STEP_ROWS, 7'd7);
    add_reg(mpw_pkg::REG_STEP_COLS, 7'd7);
    add_checked(16'h7FFF, 1'b1, 4'd0, 6'd0, 6'd0, 1'b0);
    add_checked(16'h8000, 1'b0, 4'd1, 6'd0, 6'd0, 1'b0);
    // shrink channel count mid-frame; counter sits past its bound
    add_reg(mpw_pkg::REG_NUM_CHANNELS, 7'd1);
    add_reg(mpw_pkg::REG_FRAME_HEIGHT, 7'd4);
    add_reg(mpw_pkg::REG_FRAME_WIDTH, 7'd4);
    add_reg(mpw_pkg::REG_WINDOW_HEIGHT, 7'd2);
    add_reg(mpw_pkg::REG_WINDOW_WIDTH, 7'd2);
    add_reg(mpw_pkg::REG_STEP_ROWS, 7'd1);
    add_reg(mpw_pkg::REG_STEP_COLS, 7'd1);
    add_sample(16'h0123, 1'b0);
    add_sample(16'hF000, 1'b0);
    add_sample(16'h0456, 1'b0);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h0789, 1'b0);
    add_sample(16'hFFFE, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    in_regs = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!in_regs) begin
          settle();
          in_regs = 1'b1;
        end
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        if (in_regs) begin
          cfg_we  <= 1'b0;
          in_regs = 1'b0;
        end
        send_sample(dir_rows[i].value, dir_rows[i].fs, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // corner settings: deepest channels, tallest and widest frames, largest window/stride
    run_phase(7'd16, 7'd3, 7'd3, 7'd2, 7'd2, 7'd1, 7'd1, 144, 1'b1);
    run_phase(7'd1, 7'd64, 7'd1, 7'd4, 7'd1, 7'd4, 7'd1, 64, 1'b1);
    run_phase(7'd1, 7'd2, 7'd64, 7'd1, 7'd4, 7'd1, 7'd4, 128, 1'b1);
    run_phase(7'd2, 7'd8, 7'd8, 7'd4, 7'd4, 7'd4, 7'd4, 128, 1'b1);

    while (samples_sent < TARGET_SAMPLES) begin
      if ($urandom_range(0, 9) == 0) r_nc = 7'($urandom_range(0, 31));
      else if ($urandom_range(0, 4) == 0) r_nc = 7'($urandom_range(4, 16));
      else r_nc = 7'($urandom_range(1, 3));
      r_fh = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 10));
      r_fw = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 10));
      r_wh = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(1, 4));
      r_ww = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(1, 4));
      r_sr = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(1, 4));
      r_sc = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(1, 4));
      frame = clampi(int'(r_nc[4:0]), 1, mpw_pkg::MAX_CHANNELS_DEF) *
              clampi(int'(r_fh), 1, mpw_pkg::MAX_HEIGHT_DEF) *
              clampi(int'(r_fw), 1, mpw_pkg::MAX_WIDTH_DEF);
      // mostly whole frames; a partial run can leave the next phase starting mid-frame
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame);
      else count = frame * $urandom_range(1, 3);
      if (count > 160) count = 160;
      run_phase(r_nc, r_fh, r_fw, r_wh, r_ww, r_sr, r_sc, count, $urandom_range(0, 1));
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/mpw_pkg.sv
hw/rtl/mpw_ram.sv
hw/rtl/mpw_queue.sv
hw/rtl/mpw_front.sv
hw/rtl/mpw_back.sv
hw/rtl/max_pooling_window_stream.sv
hw/rtl/mpw_checker.sv
tb/max_pooling_window_stream_tb.sv
